// ----- src/uart_buffered_rx_tx_engine_assert.svh -----
// Assertion macros for the buffered UART receive/transmit engine
`ifndef UART_BUFFERED_RX_TX_ENGINE_ASSERT_SVH
`define UART_BUFFERED_RX_TX_ENGINE_ASSERT_SVH

// same-cycle implication
`define UBRTE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ubrte check failed");

// next-cycle implication
`define UBRTE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ubrte check failed");

`endif

// ----- src/ubrte_pkg.sv -----
// Package: sizes, codes and types shared by the UART ring buffer engine
`default_nettype none

package ubrte_pkg;

    localparam int TX_DEPTH = 32;
    localparam int RX_DEPTH = 32;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int PTR_W    = (TX_AW > RX_AW) ? TX_AW : RX_AW;
    localparam int RX_CW    = (RX_AW + 1 > 5) ? RX_AW + 1 : 5;
    localparam int QDEPTH   = 2;
    localparam int QAW      = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
    localparam int PEND_W   = $clog2(QDEPTH + 2);

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_PLAIN   = 2'd0,
        CMD_TX_BYTE = 2'd1,
        CMD_RX_READ = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_WAIT = 2'd1,
        BK_EMIT = 2'd2
    } t_back_state;

    typedef struct packed {
        logic        rx_nonempty;
        logic        tx_idle;
        logic        tx_irq_enabled;
        logic [15:0] error_total;
    } t_status;

    typedef struct packed {
        t_cmd_kind        kind;
        logic             accepted;
        logic [PTR_W-1:0] ptr;
        logic [4:0]       cnt;
        t_status          status;
    } t_cmd;

    typedef struct packed {
        logic    write_accepted;
        logic    byte_valid;
        logic [7:0] out_byte;
        logic    last;
        t_status status;
    } t_result;

    typedef struct packed {
        logic tx_done;
        logic rx_done;
    } t_done;

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- src/uart_buffered_rx_tx_engine.sv -----
// Top level: buffered UART receive/transmit ring engine
//
// Input channel: push/full. Each item is a host write (mode 0), a host read
// (mode 1) or a line event (mode 2); it is taken when push is high and full low.
// Result channel: empty/pop. A result sits on the o_ ports while empty is low
// and leaves on a cycle with pop high. Writes, line events and unused modes give
// one result; a read gives one result per byte handed out, last on the final one, or one result if no byte.
// An item passes from the command queue through the back part's idle and emit
// states into the result register; one carrying a ring byte also passes a wait
// state before each byte, set by the registered ring read port. The back part
// takes the next item only once the last result of the current one is loaded.
// Items pass through a two-entry command queue, so the front keeps taking items
// while results wait. A write, or a line event with a received byte, is held
// back while a read of that same ring is still pending.
// Reset (synchronous, active low) empties both rings and the queue, zeroes the
// error count and clears the transmit interrupt enable; ring contents are kept.
// When pop stays low the result register holds; the queue then fills and full
// rises.
`default_nettype none

module uart_buffered_rx_tx_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_write_byte,
    input  logic [4:0]  i_read_limit,
    input  logic        i_error_flag,
    input  logic        i_status_error,
    input  logic        i_rx_complete_flag,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_tx_empty_flag,
    output logic        empty,
    input  logic        pop,
    output logic        o_write_accepted,
    output logic        o_byte_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_rx_nonempty,
    output logic        o_tx_idle,
    output logic        o_tx_irq_enabled,
    output logic [15:0] o_error_total
);
    import ubrte_pkg::*;

    logic             q_full, q_push, q_empty, q_pop;
    t_cmd             f_cmd, q_cmd;
    t_done            done;
    t_result          result;
    logic             tx_we, rx_we;
    logic [TX_AW-1:0] tx_waddr, tx_raddr;
    logic [RX_AW-1:0] rx_waddr, rx_raddr;
    logic [7:0]       tx_wdata, tx_rdata, rx_wdata, rx_rdata;

    ubrte_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_mode             (i_mode),
        .i_write_byte       (i_write_byte),
        .i_read_limit       (i_read_limit),
        .i_error_flag       (i_error_flag),
        .i_status_error     (i_status_error),
        .i_rx_complete_flag (i_rx_complete_flag),
        .i_rx_byte          (i_rx_byte),
        .i_tx_empty_flag    (i_tx_empty_flag),
        .o_full             (full),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_cmd              (f_cmd),
        .i_done             (done),
        .o_tx_we            (tx_we),
        .o_tx_waddr         (tx_waddr),
        .o_tx_wdata         (tx_wdata),
        .o_rx_we            (rx_we),
        .o_rx_waddr         (rx_waddr),
        .o_rx_wdata         (rx_wdata)
    );

    ubrte_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    ubrte_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    ubrte_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    ubrte_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_cmd      (q_cmd),
        .o_q_pop    (q_pop),
        .o_tx_raddr (tx_raddr),
        .i_tx_rdata (tx_rdata),
        .o_rx_raddr (rx_raddr),
        .i_rx_rdata (rx_rdata),
        .o_done     (done),
        .o_result   (result),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    assign o_write_accepted = result.write_accepted;
    assign o_byte_valid     = result.byte_valid;
    assign o_out_byte       = result.out_byte;
    assign o_last           = result.last;
    assign o_rx_nonempty    = result.status.rx_nonempty;
    assign o_tx_idle        = result.status.tx_idle;
    assign o_tx_irq_enabled = result.status.tx_irq_enabled;
    assign o_error_total    = result.status.error_total;

endmodule

`default_nettype wire

// ----- src/ubrte_ram.sv -----
// Generic one-write one-read RAM with registered read data
`default_nettype none

module ubrte_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/ubrte_cmdq.sv -----
// Short command queue between the front and back parts
`default_nettype none

module ubrte_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ubrte_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output ubrte_pkg::t_cmd o_cmd,
    output logic            o_empty
);
    import ubrte_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           do_push, do_pop;

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_full  = (r_cnt == (QAW + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

endmodule

`default_nettype wire

// ----- src/ubrte_front.sv -----
// Front part: accepts items, updates ring pointers and counters, issues commands
`default_nettype none

module ubrte_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [1:0]                 i_mode,
    input  logic [7:0]                 i_write_byte,
    input  logic [4:0]                 i_read_limit,
    input  logic                       i_error_flag,
    input  logic                       i_status_error,
    input  logic                       i_rx_complete_flag,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_tx_empty_flag,
    output logic                       o_full,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output ubrte_pkg::t_cmd            o_cmd,
    input  ubrte_pkg::t_done           i_done,
    output logic                       o_tx_we,
    output logic [ubrte_pkg::TX_AW-1:0] o_tx_waddr,
    output logic [7:0]                 o_tx_wdata,
    output logic                       o_rx_we,
    output logic [ubrte_pkg::RX_AW-1:0] o_rx_waddr,
    output logic [7:0]                 o_rx_wdata
);
    import ubrte_pkg::*;

    logic [TX_AW-1:0]  r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [RX_AW-1:0]  r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [15:0]       r_err, n_err;
    logic              r_irq, n_irq;
    logic [PEND_W-1:0] r_tx_pend, n_tx_pend, r_rx_pend, n_rx_pend;

    t_mode             mode;
    logic [TX_AW-1:0]  tx_nx, s_tx_head, s_tx_tail;
    logic [RX_AW-1:0]  rx_nx, s_rx_head, s_rx_tail;
    logic [RX_CW-1:0]  rx_cnt, lim, rd_n;
    logic [RX_CW:0]    tail_sum, tail_wrap;
    logic [1:0]        inc;
    logic [16:0]       err_sum;
    logic [15:0]       s_err;
    logic              s_irq, tx_issue, rx_issue, tx_we, rx_we, hazard, acc;
    t_cmd              cmd;

    always_comb begin
        mode  = t_mode'(i_mode);
        tx_nx = tx_next(r_tx_head);
        rx_nx = rx_next(r_rx_head);

        if (r_rx_head >= r_rx_tail) begin
            rx_cnt = RX_CW'(r_rx_head) - RX_CW'(r_rx_tail);
        end else begin
            rx_cnt = RX_CW'(r_rx_head) + RX_CW'(RX_DEPTH) - RX_CW'(r_rx_tail);
        end
        lim       = RX_CW'(i_read_limit);
        rd_n      = (lim < rx_cnt) ? lim : rx_cnt;
        tail_sum  = (RX_CW + 1)'(r_rx_tail) + (RX_CW + 1)'(rd_n);
        tail_wrap = (tail_sum >= (RX_CW + 1)'(RX_DEPTH)) ?
                    tail_sum - (RX_CW + 1)'(RX_DEPTH) : tail_sum;

        s_tx_head = r_tx_head;
        s_tx_tail = r_tx_tail;
        s_rx_head = r_rx_head;
        s_rx_tail = r_rx_tail;
        s_irq     = r_irq;
        inc       = 2'd0;
        tx_issue  = 1'b0;
        rx_issue  = 1'b0;
        tx_we     = 1'b0;
        rx_we     = 1'b0;
        cmd       = '0;
        cmd.kind  = CMD_PLAIN;

        case (mode)
            MODE_WRITE: begin
                if (tx_nx != r_tx_tail) begin
                    tx_we        = 1'b1;
                    s_tx_head    = tx_nx;
                    s_irq        = 1'b1;
                    cmd.accepted = 1'b1;
                end
            end
            MODE_READ: begin
                if (rd_n != '0) begin
                    cmd.kind  = CMD_RX_READ;
                    cmd.ptr   = PTR_W'(r_rx_tail);
                    cmd.cnt   = rd_n[4:0];
                    s_rx_tail = tail_wrap[RX_AW-1:0];
                    rx_issue  = 1'b1;
                end
            end
            MODE_LINE: begin
                if (i_error_flag && i_status_error) begin
                    inc = inc + 2'd1;
                end
                if (i_rx_complete_flag) begin
                    if (rx_nx != r_rx_tail) begin
                        rx_we     = 1'b1;
                        s_rx_head = rx_nx;
                    end else begin
                        inc = inc + 2'd1;
                    end
                end
                if (i_tx_empty_flag) begin
                    if (r_tx_tail != r_tx_head) begin
                        cmd.kind  = CMD_TX_BYTE;
                        cmd.ptr   = PTR_W'(r_tx_tail);
                        s_tx_tail = tx_next(r_tx_tail);
                        tx_issue  = 1'b1;
                    end else begin
                        s_irq = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        err_sum = 17'(r_err) + 17'(inc);
        s_err   = err_sum[16] ? 16'hFFFF : err_sum[15:0];

        cmd.status.rx_nonempty    = (s_rx_head != s_rx_tail);
        cmd.status.tx_idle        = (s_tx_head == s_tx_tail);
        cmd.status.tx_irq_enabled = s_irq;
        cmd.status.error_total    = s_err;

        // a ring slot freed by a pending read may not be refilled before it is read
        hazard = ((mode == MODE_WRITE) && (r_tx_pend != '0)) ||
                 ((mode == MODE_LINE) && i_rx_complete_flag && (r_rx_pend != '0));
        o_full = i_q_full || hazard;
        acc    = i_push && !o_full;

        n_tx_head = acc ? s_tx_head : r_tx_head;
        n_tx_tail = acc ? s_tx_tail : r_tx_tail;
        n_rx_head = acc ? s_rx_head : r_rx_head;
        n_rx_tail = acc ? s_rx_tail : r_rx_tail;
        n_irq     = acc ? s_irq : r_irq;
        n_err     = acc ? s_err : r_err;
        n_tx_pend = r_tx_pend + PEND_W'(acc && tx_issue) - PEND_W'(i_done.tx_done);
        n_rx_pend = r_rx_pend + PEND_W'(acc && rx_issue) - PEND_W'(i_done.rx_done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head <= '0;
            r_tx_tail <= '0;
            r_rx_head <= '0;
            r_rx_tail <= '0;
            r_err     <= '0;
            r_irq     <= 1'b0;
            r_tx_pend <= '0;
            r_rx_pend <= '0;
        end else begin
            r_tx_head <= n_tx_head;
            r_tx_tail <= n_tx_tail;
            r_rx_head <= n_rx_head;
            r_rx_tail <= n_rx_tail;
            r_err     <= n_err;
            r_irq     <= n_irq;
            r_tx_pend <= n_tx_pend;
            r_rx_pend <= n_rx_pend;
        end
    end

    assign o_q_push   = acc;
    assign o_cmd      = cmd;
    assign o_tx_we    = acc && tx_we;
    assign o_tx_waddr = r_tx_head;
    assign o_tx_wdata = i_write_byte;
    assign o_rx_we    = acc && rx_we;
    assign o_rx_waddr = r_rx_head;
    assign o_rx_wdata = i_rx_byte;

endmodule

`default_nettype wire

// ----- src/ubrte_back.sv -----
// Back part: runs commands, reads the rings and holds the result register
`default_nettype none

module ubrte_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  ubrte_pkg::t_cmd             i_cmd,
    output logic                        o_q_pop,
    output logic [ubrte_pkg::TX_AW-1:0] o_tx_raddr,
    input  logic [7:0]                  i_tx_rdata,
    output logic [ubrte_pkg::RX_AW-1:0] o_rx_raddr,
    input  logic [7:0]                  i_rx_rdata,
    output ubrte_pkg::t_done            o_done,
    output ubrte_pkg::t_result          o_result,
    output logic                        o_empty,
    input  logic                        i_pop
);
    import ubrte_pkg::*;

    t_back_state      r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [4:0]       r_left, n_left;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    t_result          r_out, n_out;
    logic             r_out_valid;
    logic             out_free, load;

    always_comb begin
        out_free = !r_out_valid || i_pop;
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_left   = r_left;
        n_ptr    = r_ptr;
        n_out    = r_out;
        load     = 1'b0;
        o_q_pop  = 1'b0;
        o_done   = '0;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    n_ptr   = i_cmd.ptr;
                    n_left  = i_cmd.cnt;
                    n_state = (i_cmd.kind == CMD_PLAIN) ? BK_EMIT : BK_WAIT;
                end
            end
            BK_WAIT: begin
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (out_free) begin
                    load                 = 1'b1;
                    n_out.write_accepted = r_cmd.accepted;
                    n_out.status         = r_cmd.status;
                    n_out.byte_valid     = 1'b0;
                    n_out.out_byte       = 8'd0;
                    n_out.last           = 1'b1;
                    n_state              = BK_IDLE;
                    case (r_cmd.kind)
                        CMD_TX_BYTE: begin
                            n_out.byte_valid = 1'b1;
                            n_out.out_byte   = i_tx_rdata;
                            o_done.tx_done   = 1'b1;
                        end
                        CMD_RX_READ: begin
                            n_out.byte_valid = 1'b1;
                            n_out.out_byte   = i_rx_rdata;
                            if (r_left == 5'd1) begin
                                o_done.rx_done = 1'b1;
                            end else begin
                                n_out.last = 1'b0;
                                n_left     = r_left - 5'd1;
                                n_ptr      = PTR_W'(rx_next(r_ptr[RX_AW-1:0]));
                                n_state    = BK_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_left <= n_left;
        r_ptr  <= n_ptr;
        r_out  <= n_out;
    end

    assign o_tx_raddr = r_ptr[TX_AW-1:0];
    assign o_rx_raddr = r_ptr[RX_AW-1:0];
    assign o_result   = r_out;
    assign o_empty    = !r_out_valid;

endmodule

`default_nettype wire

// ----- src/ubrte_checker.sv -----
// Port-level checker for the UART ring buffer engine, bound to the top level
`default_nettype none

`include "uart_buffered_rx_tx_engine_assert.svh"

module ubrte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_write_accepted,
    input logic        o_byte_valid,
    input logic [7:0]  o_out_byte,
    input logic        o_last,
    input logic        o_tx_idle,
    input logic        o_tx_irq_enabled,
    input logic [15:0] o_error_total
);

    logic [24:0] shown;
    logic        write_shape;

    assign shown       = {o_out_byte, o_last, o_error_total};
    assign write_shape = !o_byte_valid && o_last && !o_tx_idle && o_tx_irq_enabled;

    `UBRTE_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(shown))

    `UBRTE_ASSERT_IMP(a_no_byte_zero, i_clk, i_rst_n, !empty && !o_byte_valid, o_out_byte == 8'd0)

    `UBRTE_ASSERT_IMP(a_write_result, i_clk, i_rst_n, !empty && o_write_accepted, write_shape)

    `UBRTE_ASSERT_IMP(a_mid_read, i_clk, i_rst_n, !empty && !o_last, o_byte_valid && !o_write_accepted)

endmodule

bind uart_buffered_rx_tx_engine ubrte_checker u_ubrte_checker (.*);

`default_nettype wire

// ----- test/uart_buffered_rx_tx_engine_test.sv -----
// Self-checking testbench for the buffered UART receive/transmit ring engine
`default_nettype none

module uart_buffered_rx_tx_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ubrte_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 300;
    localparam int HOLD_CYCLES    = 160;
    localparam int ERR_EVENTS     = 8;

    typedef struct {
        t_mode      mode;
        logic [7:0] wbyte;
        logic [4:0] limit;
        logic       err;
        logic       stat;
        logic       rxc;
        logic [7:0] rbyte;
        logic       dre;
    } t_host_item;

    typedef enum int {
        MIX_RUN,
        TX_FILL,
        RX_FILL,
        READ_RUN,
        TX_DRAIN
    } t_burst_kind;

    class ring_scoreboard;
        logic [7:0]  tx_ring [TX_DEPTH];
        logic [7:0]  rx_ring [RX_DEPTH];
        int          tx_head, tx_tail, rx_head, rx_tail;
        int unsigned err_cnt;
        bit          irq_en;
        t_result     expected_q [$];
        int unsigned fails;
        int unsigned checked;

        function new();
            tx_head = 0;
            tx_tail = 0;
            rx_head = 0;
            rx_tail = 0;
            err_cnt = 0;
            irq_en  = 1'b0;
            fails   = 0;
            checked = 0;
        endfunction

        function int bump(int p, int depth);
            return (p + 1 >= depth) ? 0 : p + 1;
        endfunction

        function void count_error();
            if (err_cnt < 65535) begin
                err_cnt++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // work out the results of one accepted item and queue them
        function void note_item(t_host_item it);
            logic [7:0] popped [$];
            t_result    r;
            bit         accepted;
            int         nx;
            accepted = 1'b0;
            case (it.mode)
                MODE_WRITE: begin
                    nx = bump(tx_head, TX_DEPTH);
                    if (nx != tx_tail) begin
                        tx_ring[tx_head] = it.wbyte;
                        tx_head = nx;
                        irq_en = 1'b1;
                        accepted = 1'b1;
                    end
                end
                MODE_READ: begin
                    while (rx_tail != rx_head && popped.size() < int'(it.limit)) begin
                        popped.push_back(rx_ring[rx_tail]);
                        rx_tail = bump(rx_tail, RX_DEPTH);
                    end
                end
                MODE_LINE: begin
                    if (it.err && it.stat) begin
                        count_error();
                    end
                    if (it.rxc) begin
                        nx = bump(rx_head, RX_DEPTH);
                        if (nx != rx_tail) begin
                            rx_ring[rx_head] = it.rbyte;
                            rx_head = nx;
                        end else begin
                            count_error();
                        end
                    end
                    if (it.dre) begin
                        if (tx_tail != tx_head) begin
                            popped.push_back(tx_ring[tx_tail]);
                            tx_tail = bump(tx_tail, TX_DEPTH);
                        end else begin
                            irq_en = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
            r = '0;
            r.write_accepted        = accepted;
            r.status.rx_nonempty    = (rx_head != rx_tail);
            r.status.tx_idle        = (tx_head == tx_tail);
            r.status.tx_irq_enabled = irq_en;
            r.status.error_total    = err_cnt[15:0];
            if (popped.size() == 0) begin
                r.last = 1'b1;
                expected_q.push_back(r);
            end else begin
                foreach (popped[k]) begin
                    r.byte_valid = 1'b1;
                    r.out_byte   = popped[k];
                    r.last       = (k == popped.size() - 1);
                    expected_q.push_back(r);
                end
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] result %0d: %s", $realtime, checked, what);
            fails++;
        endtask

        task check_result(t_result got);
            t_result want;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("result arrived with none expected");
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("got %h want %h", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n            = 1'b0;
    logic        push               = 1'b0;
    logic        full;
    logic [1:0]  i_mode             = '0;
    logic [7:0]  i_write_byte       = '0;
    logic [4:0]  i_read_limit       = '0;
    logic        i_error_flag       = 1'b0;
    logic        i_status_error     = 1'b0;
    logic        i_rx_complete_flag = 1'b0;
    logic [7:0]  i_rx_byte          = '0;
    logic        i_tx_empty_flag    = 1'b0;
    logic        empty;
    logic        pop                = 1'b0;
    logic        o_write_accepted;
    logic        o_byte_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_rx_nonempty;
    logic        o_tx_idle;
    logic        o_tx_irq_enabled;
    logic [15:0] o_error_total;

    ring_scoreboard sb;
    t_result        got;
    int unsigned    items_sent = 0;
    int unsigned    quiet_cycles = 0;
    bit             hold_req = 1'b0;
    bit             rx_idle_on = 1'b1;

    uart_buffered_rx_tx_engine dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            got.write_accepted        = o_write_accepted;
            got.byte_valid            = o_byte_valid;
            got.out_byte              = o_out_byte;
            got.last                  = o_last;
            got.status.rx_nonempty    = o_rx_nonempty;
            got.status.tx_idle        = o_tx_idle;
            got.status.tx_irq_enabled = o_tx_irq_enabled;
            got.status.error_total    = o_error_total;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random pop bursts, one long hold-off on request
    initial begin : result_side
        int n;
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                n = $urandom_range(1, 20);
                do begin
                    @(posedge i_clk);
                    n--;
                end while (n > 0 && !hold_req);
            end
        end
    end

    function automatic t_host_item rand_item(t_mode m);
        t_host_item it;
        it.mode  = m;
        it.wbyte = 8'($urandom_range(0, 255));
        it.limit = 5'($urandom_range(0, 31));
        it.err   = 1'($urandom_range(0, 1));
        it.stat  = 1'($urandom_range(0, 1));
        it.rxc   = 1'($urandom_range(0, 1));
        it.rbyte = 8'($urandom_range(0, 255));
        it.dre   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_item(t_host_item it);
        push               <= 1'b1;
        i_mode             <= it.mode;
        i_write_byte       <= it.wbyte;
        i_read_limit       <= it.limit;
        i_error_flag       <= it.err;
        i_status_error     <= it.stat;
        i_rx_complete_flag <= it.rxc;
        i_rx_byte          <= it.rbyte;
        i_tx_empty_flag    <= it.dre;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
        if (it.mode != MODE_NONE) begin
            items_sent++;
        end
    endtask

    task automatic write_op(logic [7:0] b);
        t_host_item it;
        it = rand_item(MODE_WRITE);
        it.wbyte = b;
        send_item(it);
    endtask

    task automatic read_op(logic [4:0] lim);
        t_host_item it;
        it = rand_item(MODE_READ);
        it.limit = lim;
        send_item(it);
    endtask

    task automatic line_op(logic err, logic stat, logic rxc, logic [7:0] rb, logic dre);
        t_host_item it;
        it = rand_item(MODE_LINE);
        it.err   = err;
        it.stat  = stat;
        it.rxc   = rxc;
        it.rbyte = rb;
        it.dre   = dre;
        send_item(it);
    endtask

    task automatic sender_gap();
        push <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    initial begin : stimulus
        t_host_item  it;
        t_burst_kind kind;
        int          burst;
        int          gap_odds;
        bit          held_once;
        bit          paused_once;
        held_once   = 1'b0;
        paused_once = 1'b0;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        read_op(5'd5);
        line_op(1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
        write_op(8'h00);
        write_op(8'hFF);
        write_op(8'hA5);
        read_op(5'd0);
        line_op(1'b1, 1'b1, 1'b0, 8'h00, 1'b1);
        line_op(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
        line_op(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        line_op(1'b0, 1'b0, 1'b1, 8'hFF, 1'b0);
        line_op(1'b0, 1'b0, 1'b1, 8'h00, 1'b0);
        line_op(1'b1, 1'b1, 1'b1, 8'h5A, 1'b1);
        read_op(5'd0);
        read_op(5'd1);
        read_op(5'd31);
        line_op(1'b0, 1'b0, 1'b0, 8'hFF, 1'b1);
        line_op(1'b0, 1'b0, 1'b0, 8'hFF, 1'b1);
        it = rand_item(MODE_NONE);
        send_item(it);
        it = rand_item(MODE_NONE);
        it.wbyte = 8'hFF;
        it.limit = 5'd31;
        send_item(it);
        read_op(5'd31);
        write_op(8'h81);
        line_op(1'b1, 1'b1, 1'b1, 8'h7E, 1'b0);

        while (items_sent < RANDOM_ITEMS) begin
            kind       = t_burst_kind'($urandom_range(0, 4));
            burst      = $urandom_range(1, 12);
            gap_odds   = $urandom_range(0, 2);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            if (kind == TX_FILL || kind == RX_FILL || kind == TX_DRAIN) begin
                burst = $urandom_range(1, 40);
            end
            if (items_sent >= 120 && !held_once) begin
                held_once = 1'b1;
                hold_req  = 1'b1;
                kind      = TX_FILL;
                burst     = 30;
                gap_odds  = 0;
            end
            if (items_sent >= 240 && !paused_once) begin
                paused_once = 1'b1;
                drain_results();
            end
            repeat (burst) begin
                case (kind)
                    TX_FILL: begin
                        it = rand_item(MODE_WRITE);
                    end
                    RX_FILL: begin
                        it = rand_item(MODE_LINE);
                        it.rxc = 1'b1;
                        it.dre = ($urandom_range(0, 3) == 0);
                    end
                    READ_RUN: begin
                        it = rand_item(MODE_READ);
                        if ($urandom_range(0, 3) == 0) begin
                            it.limit = 5'($urandom_range(0, 3));
                        end
                    end
                    TX_DRAIN: begin
                        it = rand_item(MODE_LINE);
                        it.dre = 1'b1;
                    end
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            it = rand_item(MODE_NONE);
                        end else begin
                            it = rand_item(t_mode'($urandom_range(0, 2)));
                        end
                    end
                endcase
                send_item(it);
                if (gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0) begin
                    sender_gap();
                end
            end
        end

        // final stretch at full rate: overflow the receive ring and pile up errors
        rx_idle_on = 1'b0;
        repeat (RX_DEPTH) begin
            line_op(1'b0, 1'b0, 1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        repeat (ERR_EVENTS) begin
            line_op(1'b1, 1'b1, 1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        line_op(1'b1, 1'b1, 1'b1, 8'h3C, 1'b1);
        read_op(5'd31);
        read_op(5'd31);
        write_op(8'hC3);
        line_op(1'b1, 1'b1, 1'b0, 8'h00, 1'b1);
        line_op(1'b0, 1'b0, 1'b0, 8'h00, 1'b1);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
